>>> sv/rlyseq_pkg.sv
// Types, codes and helper functions shared by the relay actuation sequencer.
package rlyseq_pkg;

  // Input beat function codes
  typedef enum logic [1:0] {
    FN_TICK10   = 2'd0,
    FN_TICK1S   = 2'd1,
    FN_COMMAND  = 2'd2,
    FN_OVERRIDE = 2'd3
  } func_t;

  // Drive styles
  typedef enum logic [1:0] {
    ST_INSIDE  = 2'd0,
    ST_LEVEL   = 2'd1,
    ST_PULSE   = 2'd2,
    ST_INVALID = 2'd3
  } style_t;

  // Relay actions
  typedef enum logic [1:0] {
    ACT_CLOSE  = 2'd0,
    ACT_TRIP   = 2'd1,
    ACT_STOP   = 2'd2,
    ACT_FRIEND = 2'd3
  } act_t;

  // Sequence phase: start waits for the first tick, then two drive pulses
  // around a gap (inside style) or one drive and a closing beat (pulse style)
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_START  = 3'd1,
    PH_DRIVE1 = 3'd2,
    PH_GAP    = 3'd3,
    PH_DRIVE2 = 3'd4
  } phase_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_REACTUATE = 2'd0,
    CFG_DRIVE     = 2'd1,
    CFG_GAP       = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIMER_W    = 13;
  localparam int unsigned REACT_W    = 16;

  localparam logic [REACT_W-1:0] REACT_RESET = 16'(151 * 60);
  localparam logic [7:0]         DRIVE_RESET = 8'd20;
  localparam logic [7:0]         GAP_RESET   = 8'd60;

  // Reciprocal of ten, exact for every 16-bit dividend with a shift of 19
  localparam logic [31:0] RECIP10       = 32'd52429;
  localparam int unsigned RECIP10_SHIFT = 19;
  localparam int unsigned MS_PER_TICK   = 10;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  drive_style;
    logic [1:0]  action;
    logic [15:0] pulse_ms;
  } in_t;

  typedef struct packed {
    logic       drive_valid;
    logic [1:0] drive_action;
    logic [1:0] drive_style_out;
    logic       busy_res;
    logic [1:0] stored_action;
  } out_t;

  typedef struct packed {
    logic [REACT_W-1:0] reactuate_seconds;
    logic [7:0]         inside_drive_ticks;
    logic [7:0]         inside_gap_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    style_t             stored_style;
    act_t               stored_act;
    logic [TIMER_W-1:0] step_timer;
    logic [TIMER_W-1:0] pulse_ticks;
    logic [REACT_W-1:0] reactuate_timer;
  } seq_state_t;

  // Milliseconds to 10 ms ticks by reciprocal multiply
  function automatic logic [TIMER_W-1:0] ms_to_ticks(input logic [15:0] ms);
    logic [31:0] prod;
    prod = {16'd0, ms} * RECIP10;
    return prod[RECIP10_SHIFT +: TIMER_W];
  endfunction

  // A stored friend action drives as stop
  function automatic logic [1:0] act_out(input act_t act);
    return (act == ACT_FRIEND) ? ACT_STOP : act;
  endfunction

  // Stop and friend never start a sequence
  function automatic logic can_launch(input logic [1:0] act);
    return (act != ACT_STOP) && (act != ACT_FRIEND);
  endfunction

endpackage

>>> sv/relay_actuation_sequencer_core.sv
// Top level of the relay actuation sequencer: beat registers and sequence state.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one beat per event:
//   a 10 ms tick, a one-second tick, a new relay command or an override of
//   the stored action. Every input beat yields exactly one result beat on
//   the output channel (out_valid/out_ready/out_data), in order.
//   A beat is captured into an input register, then one pass of next-state
//   logic updates the sequence state and loads the result register.
//   A beat accepted into the input register moves on to out_data through the
//   result register once that register is free. Throughput: one beat per
//   cycle while results keep draining, set by the single state update per
//   beat; the only multiply (ms to ticks) sits in that pass.
//   Stall: while out_ready is low with a result held, the input register
//   still takes one more beat, then in_ready drops until the result moves.
//   Reset (rst_n low, synchronous): sequence idle, all timers zero, stored
//   command cleared, configuration registers back to their defaults.
//   The user writes configuration (cfg_we/cfg_addr/cfg_wdata) only while idle; the block does not enforce it.
module relay_actuation_sequencer_core import rlyseq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t       cfg;
  in_t        in_r;
  logic       in_vld_r;
  logic       in_vld_nxt;
  out_t       out_r;
  out_t       out_nxt;
  logic       out_vld_r;
  logic       out_vld_nxt;
  seq_state_t st_r;
  seq_state_t st_nxt;
  logic       adv;
  logic       in_take;

  rlyseq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rlyseq_step u_step (
    .item   (in_r),
    .st     (st_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (out_nxt)
  );

  // Advance the held beat when the result register is empty or draining
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control and sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '{phase: PH_IDLE, stored_style: ST_INSIDE, stored_act: ACT_CLOSE,
                     default: '0};
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload: hold until the next beat moves in
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_busy_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_r.busy_res == (st_r.phase != PH_IDLE))
            && (out_r.stored_action == st_r.stored_act))
    else $error("result busy/stored action disagree with sequence state");

  a_no_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.drive_valid) |->
      (out_r.drive_action == ACT_CLOSE) && (out_r.drive_style_out == ST_INSIDE))
    else $error("idle result carries drive fields");

  a_drive_codes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.drive_valid) |->
      (out_r.drive_action != ACT_FRIEND) && (out_r.drive_style_out != ST_INVALID))
    else $error("drive reports friend action or invalid style");

  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pulse_ticks <= TIMER_W'(65535 / MS_PER_TICK))
    else $error("pulse tick count out of range");
`endif

endmodule

>>> sv/rlyseq_cfg.sv
// Configuration register file of the relay actuation sequencer.
module rlyseq_cfg import rlyseq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_REACTUATE: cfg_nxt.reactuate_seconds  = cfg_wdata;
        CFG_DRIVE:     cfg_nxt.inside_drive_ticks = cfg_wdata[7:0];
        CFG_GAP:       cfg_nxt.inside_gap_ticks   = cfg_wdata[7:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reactuate_seconds  <= REACT_RESET;
      cfg_r.inside_drive_ticks <= DRIVE_RESET;
      cfg_r.inside_gap_ticks   <= GAP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/rlyseq_step.sv
// Next-state and result logic for one beat of the relay actuation sequencer.
module rlyseq_step import rlyseq_pkg::*; (
  input  in_t        item,
  input  seq_state_t st,
  input  cfg_t       cfg,
  output seq_state_t st_nxt,
  output out_t       res
);

  logic [TIMER_W-1:0] tmr_dec;
  logic [REACT_W-1:0] react_dec;

  always_comb begin
    st_nxt    = st;
    res       = '0;
    tmr_dec   = (st.step_timer != '0) ? st.step_timer - 1'b1 : '0;
    react_dec = (st.reactuate_timer != '0) ? st.reactuate_timer - 1'b1 : '0;

    unique case (func_t'(item.func))
      FN_TICK10: begin
        if (st.phase != PH_IDLE) begin
          st_nxt.step_timer = tmr_dec;
          if (tmr_dec == '0) begin
            unique case (st.stored_style)
              ST_INSIDE: begin
                res.drive_valid     = 1'b1;
                res.drive_style_out = ST_INSIDE;
                unique case (st.phase)
                  PH_START, PH_GAP: begin
                    st_nxt.phase      = (st.phase == PH_START) ? PH_DRIVE1 : PH_DRIVE2;
                    st_nxt.step_timer = TIMER_W'(cfg.inside_drive_ticks);
                    res.drive_action  = act_out(st.stored_act);
                  end
                  PH_DRIVE1: begin
                    st_nxt.phase      = PH_GAP;
                    st_nxt.step_timer = TIMER_W'(cfg.inside_gap_ticks);
                    res.drive_action  = ACT_STOP;
                  end
                  default: begin
                    st_nxt.phase     = PH_IDLE;
                    res.drive_action = ACT_STOP;
                  end
                endcase
              end
              ST_LEVEL: begin
                st_nxt.phase        = PH_IDLE;
                res.drive_valid     = 1'b1;
                res.drive_style_out = ST_LEVEL;
                res.drive_action    = act_out(st.stored_act);
              end
              ST_PULSE: begin
                res.drive_valid     = 1'b1;
                res.drive_style_out = ST_PULSE;
                if (st.phase == PH_START) begin
                  st_nxt.phase      = PH_DRIVE1;
                  st_nxt.step_timer = st.pulse_ticks;
                  res.drive_action  = act_out(st.stored_act);
                end else begin
                  st_nxt.phase     = PH_IDLE;
                  res.drive_action = ACT_CLOSE;
                end
              end
              default: begin
                // invalid style: stay busy, never drive
                st_nxt.phase = st.phase;
              end
            endcase
          end
        end
      end
      FN_TICK1S: begin
        if (st.reactuate_timer != '0) begin
          st_nxt.reactuate_timer = react_dec;
          // reissue keeps style and pulse length, only restarts the sequence
          if (react_dec == '0 && st.phase == PH_IDLE && can_launch(st.stored_act)) begin
            st_nxt.step_timer      = TIMER_W'(1);
            st_nxt.reactuate_timer = cfg.reactuate_seconds;
            st_nxt.phase           = PH_START;
          end
        end
      end
      FN_COMMAND: begin
        if (can_launch(item.action)) begin
          st_nxt.stored_style    = style_t'(item.drive_style);
          st_nxt.stored_act      = act_t'(item.action);
          st_nxt.step_timer      = TIMER_W'(1);
          st_nxt.pulse_ticks     = ms_to_ticks(item.pulse_ms);
          st_nxt.reactuate_timer = cfg.reactuate_seconds;
          st_nxt.phase           = PH_START;
        end
      end
      default: begin
        st_nxt.stored_act = act_t'(item.action);
      end
    endcase

    res.busy_res      = (st_nxt.phase != PH_IDLE);
    res.stored_action = st_nxt.stored_act;
  end

endmodule

>>> test/relay_seq_sb_pkg.sv
// Scoreboard for the relay actuation sequencer: drive predictor and result checker.
package relay_seq_sb_pkg;
  import rlyseq_pkg::*;

  class relay_seq_scoreboard;
    // Register copies
    logic [REACT_W-1:0] reactuate_secs;
    logic [7:0]         drive_len;
    logic [7:0]         gap_len;
    // Sequence state copies
    phase_t             phase;
    style_t             cmd_style;
    act_t               cmd_act;
    logic [TIMER_W-1:0] step_cnt;
    logic [TIMER_W-1:0] pulse_len;
    logic [REACT_W-1:0] reissue_cnt;

    out_t        drive_q[$];
    int unsigned mismatches;
    int unsigned beats_in;
    int unsigned beats_out;
    int unsigned drives_seen;
    int unsigned reissues;

    function new();
      clear();
      mismatches = 0;
      beats_in = 0;
      beats_out = 0;
      drives_seen = 0;
      reissues = 0;
    endfunction

    function void clear();
      reactuate_secs = REACT_RESET;
      drive_len = DRIVE_RESET;
      gap_len = GAP_RESET;
      phase = PH_IDLE;
      cmd_style = ST_INSIDE;
      cmd_act = ACT_CLOSE;
      step_cnt = '0;
      pulse_len = '0;
      reissue_cnt = '0;
      drive_q.delete();
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_REACTUATE: reactuate_secs = val;
        CFG_DRIVE:     drive_len = val[7:0];
        CFG_GAP:       gap_len = val[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return drive_q.size();
    endfunction

    // Friend is reported as stop on the relay lines
    function logic [1:0] drive_code(act_t a);
      if (a == ACT_FRIEND) return ACT_STOP;
      return a;
    endfunction

    function void launch(style_t s, act_t a, logic [15:0] ms);
      if (a == ACT_STOP || a == ACT_FRIEND) return;
      cmd_style = s;
      cmd_act = a;
      step_cnt = TIMER_W'(1);
      pulse_len = TIMER_W'(ms / 16'd10);
      reissue_cnt = reactuate_secs;
      phase = PH_START;
    endfunction

    function void note_beat(in_t b);
      out_t e;
      e = '0;
      beats_in++;
      case (func_t'(b.func))
        FN_TICK10: begin
          if (phase != PH_IDLE) begin
            if (step_cnt > 0) step_cnt--;
            if (step_cnt == 0) begin
              case (cmd_style)
                ST_INSIDE: begin
                  e.drive_valid = 1'b1;
                  e.drive_style_out = ST_INSIDE;
                  if (phase == PH_START) begin
                    phase = PH_DRIVE1;
                    step_cnt = TIMER_W'(drive_len);
                    e.drive_action = drive_code(cmd_act);
                  end else if (phase == PH_GAP) begin
                    phase = PH_DRIVE2;
                    step_cnt = TIMER_W'(drive_len);
                    e.drive_action = drive_code(cmd_act);
                  end else if (phase == PH_DRIVE1) begin
                    phase = PH_GAP;
                    step_cnt = TIMER_W'(gap_len);
                    e.drive_action = ACT_STOP;
                  end else begin
                    phase = PH_IDLE;
                    e.drive_action = ACT_STOP;
                  end
                end
                ST_LEVEL: begin
                  phase = PH_IDLE;
                  e.drive_valid = 1'b1;
                  e.drive_style_out = ST_LEVEL;
                  e.drive_action = drive_code(cmd_act);
                end
                ST_PULSE: begin
                  e.drive_valid = 1'b1;
                  e.drive_style_out = ST_PULSE;
                  if (phase == PH_START) begin
                    phase = PH_DRIVE1;
                    step_cnt = pulse_len;
                    e.drive_action = drive_code(cmd_act);
                  end else begin
                    phase = PH_IDLE;
                    e.drive_action = ACT_CLOSE;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        FN_TICK1S: begin
          if (reissue_cnt > 0) begin
            reissue_cnt--;
            if (reissue_cnt == 0 && phase == PH_IDLE) begin
              if (cmd_act != ACT_STOP && cmd_act != ACT_FRIEND) reissues++;
              launch(cmd_style, cmd_act, 16'({3'b000, pulse_len} * 16'd10));
            end
          end
        end
        FN_COMMAND: launch(style_t'(b.drive_style), act_t'(b.action), b.pulse_ms);
        default: cmd_act = act_t'(b.action);
      endcase
      e.busy_res = (phase != PH_IDLE);
      e.stored_action = cmd_act;
      if (e.drive_valid) drives_seen++;
      drive_q.push_back(e);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t result %0d: %s", $time, beats_out, msg);
      mismatches++;
    endtask

    task check_result(out_t r);
      out_t e;
      beats_out++;
      if (drive_q.size() == 0) begin
        report($sformatf("unexpected result %h", r));
        return;
      end
      e = drive_q.pop_front();
      if (r.drive_valid !== e.drive_valid)
        report($sformatf("drive_valid got %0d want %0d", r.drive_valid, e.drive_valid));
      if (r.drive_action !== e.drive_action)
        report($sformatf("drive_action got %0d want %0d", r.drive_action, e.drive_action));
      if (r.drive_style_out !== e.drive_style_out)
        report($sformatf("drive_style_out got %0d want %0d",
                         r.drive_style_out, e.drive_style_out));
      if (r.busy_res !== e.busy_res)
        report($sformatf("busy_res got %0d want %0d", r.busy_res, e.busy_res));
      if (r.stored_action !== e.stored_action)
        report($sformatf("stored_action got %0d want %0d", r.stored_action, e.stored_action));
    endtask
  endclass

endpackage

>>> test/tb_top.sv
// Top-level testbench for the relay actuation sequencer core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rlyseq_pkg::*;
  import relay_seq_sb_pkg::*;

  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned BEATS_PER_SET  = 150;
  localparam int unsigned PRESSURE_AFTER = 400;
  localparam int unsigned PRESSURE_HOLD  = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_we;
  logic [1:0]            cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  relay_seq_scoreboard sb;
  bit                  idle_enable;
  bit                  pressure_done;

  relay_actuation_sequencer_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Check every result beat at the rising edge where it moves
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Gap length between beats: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_t make_beat(func_t f, style_t s, act_t a, logic [15:0] ms);
    in_t b;
    b.func = f;
    b.drive_style = s;
    b.action = a;
    b.pulse_ms = ms;
    return b;
  endfunction

  // Random beat: mostly ticks that walk the sequence, well-formed commands
  // with random content, and a share of invalid styles and stop/friend noise
  function automatic in_t rand_beat();
    in_t         b;
    int unsigned r;
    b.drive_style = 2'($urandom);
    b.action = 2'($urandom);
    b.pulse_ms = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      b.func = FN_TICK10;
    end else if (r < 75) begin
      b.func = FN_TICK1S;
    end else if (r < 92) begin
      b.func = FN_COMMAND;
      if ($urandom_range(0, 99) < 85)
        b.drive_style = 2'($urandom_range(ST_INSIDE, ST_PULSE));
      if ($urandom_range(0, 99) < 80) b.action = 2'($urandom_range(ACT_CLOSE, ACT_TRIP));
      if ($urandom_range(0, 99) < 75) b.pulse_ms = 16'($urandom_range(0, 300));
    end else begin
      b.func = FN_OVERRIDE;
    end
    return b;
  endfunction

  // Offer one beat after an optional gap and hold it until accepted
  task automatic send_beat(input in_t b, input int unsigned gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = b;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(b);
  endtask

  // Drop valid and wait until every expected result has left the block
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Receiver: random holds of out_ready, plus one long hold counted here
  // while the sender keeps offering, so the block fills and stalls in_ready
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    out_ready = 1'b0;
    pressure_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!pressure_done && sb.beats_in >= PRESSURE_AFTER) begin
        pressure_done = 1'b1;
        hold = PRESSURE_HOLD;
      end else if (hold == 0 && idle_enable && $urandom_range(0, 9) == 0) begin
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Safety net: end the run if the handshakes never finish
  initial begin : watchdog
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [REACT_W-1:0] react_set[NUM_PHASES];
    logic [7:0]         drive_set[NUM_PHASES];
    logic [7:0]         gap_set[NUM_PHASES];
    in_t                dir_q[$];
    int unsigned        p;
    int unsigned        n;

    sb = new();
    idle_enable = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = CFG_REACTUATE;
    cfg_wdata = '0;

    // Settings per phase: both extremes, the defaults, zero-length timers
    // and short re-actuation times so reissues happen often
    react_set = '{16'd0, 16'hFFFF, 16'd1, 16'd3, REACT_RESET, 16'd5, 16'd2, 16'd0};
    drive_set = '{8'd0, 8'hFF, 8'd1, 8'd2, DRIVE_RESET, 8'd3, 8'd0, 8'd4};
    gap_set   = '{8'd0, 8'hFF, 8'd1, 8'd4, GAP_RESET, 8'd0, 8'd2, 8'd7};
    react_set[7] = REACT_W'($urandom_range(1, 8));
    drive_set[7] = 8'($urandom_range(0, 6));
    gap_set[7]   = 8'($urandom_range(0, 6));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed, at reset settings: level and pulse drives, ignored
    // stop/friend commands, friend driven as stop, invalid style stuck busy
    dir_q.push_back(make_beat(FN_COMMAND, ST_LEVEL, ACT_TRIP, 16'hFFFF));
    dir_q.push_back(make_beat(FN_TICK10, ST_INSIDE, ACT_CLOSE, 16'd0));
    dir_q.push_back(make_beat(FN_COMMAND, ST_PULSE, ACT_CLOSE, 16'd0));
    dir_q.push_back(make_beat(FN_TICK10, ST_INSIDE, ACT_CLOSE, 16'd0));
    dir_q.push_back(make_beat(FN_TICK10, ST_INSIDE, ACT_CLOSE, 16'd0));
    dir_q.push_back(make_beat(FN_COMMAND, ST_LEVEL, ACT_STOP, 16'd50));
    dir_q.push_back(make_beat(FN_COMMAND, ST_PULSE, ACT_FRIEND, 16'd50));
    dir_q.push_back(make_beat(FN_OVERRIDE, ST_INSIDE, ACT_FRIEND, 16'd0));
    dir_q.push_back(make_beat(FN_COMMAND, ST_INVALID, ACT_TRIP, 16'd20));
    dir_q.push_back(make_beat(FN_TICK10, ST_INSIDE, ACT_CLOSE, 16'd0));
    dir_q.push_back(make_beat(FN_TICK1S, ST_INSIDE, ACT_CLOSE, 16'd0));
    dir_q.push_back(make_beat(FN_COMMAND, ST_LEVEL, ACT_CLOSE, 16'd9));
    dir_q.push_back(make_beat(FN_OVERRIDE, ST_INSIDE, ACT_FRIEND, 16'd0));
    dir_q.push_back(make_beat(FN_TICK10, ST_INSIDE, ACT_CLOSE, 16'd0));
    foreach (dir_q[i]) send_beat(dir_q[i], 0);
    drain();
    dir_q.delete();

    // Directed, inside style with zero drive length and a two-second reissue:
    // full inside sequence, reissue when idle, expiry while busy ignored
    write_cfg(CFG_REACTUATE, 16'd2);
    write_cfg(CFG_DRIVE, 16'd0);
    write_cfg(CFG_GAP, 16'd1);
    dir_q.push_back(make_beat(FN_COMMAND, ST_INSIDE, ACT_TRIP, 16'hFFFF));
    dir_q.push_back(make_beat(FN_TICK10, ST_INSIDE, ACT_CLOSE, 16'd0));
    dir_q.push_back(make_beat(FN_TICK10, ST_INSIDE, ACT_CLOSE, 16'd0));
    dir_q.push_back(make_beat(FN_TICK1S, ST_INSIDE, ACT_CLOSE, 16'd0));
    dir_q.push_back(make_beat(FN_TICK10, ST_INSIDE, ACT_CLOSE, 16'd0));
    dir_q.push_back(make_beat(FN_TICK10, ST_INSIDE, ACT_CLOSE, 16'd0));
    dir_q.push_back(make_beat(FN_TICK1S, ST_INSIDE, ACT_CLOSE, 16'd0));
    dir_q.push_back(make_beat(FN_TICK10, ST_INSIDE, ACT_CLOSE, 16'd0));
    dir_q.push_back(make_beat(FN_TICK1S, ST_INSIDE, ACT_CLOSE, 16'd0));
    dir_q.push_back(make_beat(FN_TICK1S, ST_INSIDE, ACT_CLOSE, 16'd0));
    foreach (dir_q[i]) send_beat(dir_q[i], 0);
    drain();

    // Random phases; every third one runs without any idling on either side
    for (p = 0; p < NUM_PHASES; p++) begin
      write_cfg(CFG_REACTUATE, react_set[p]);
      write_cfg(CFG_DRIVE, {8'($urandom), drive_set[p]});
      write_cfg(CFG_GAP, {8'($urandom), gap_set[p]});
      if (p == 3) write_cfg(CFG_UNUSED, 16'($urandom));
      idle_enable = (p % 3 != 0);
      for (n = 0; n < BEATS_PER_SET; n++) send_beat(rand_beat(), pick_gap());
      drain();
    end

    // Let any stray result show up before the verdict
    repeat (20) @(posedge clk);
    $display("Run covered %0d beats over %0d register settings, %0d relay drives, %0d reissues.",
             sb.beats_in, NUM_PHASES + 2, sb.drives_seen, sb.reissues);
    $display("Receiver hold of %0d cycles applied: %0d; mismatches: %0d.",
             PRESSURE_HOLD, pressure_done, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/rlyseq_pkg.sv
sv/rlyseq_cfg.sv
sv/rlyseq_step.sv
sv/relay_actuation_sequencer_core.sv
test/relay_seq_sb_pkg.sv
test/tb_top.sv
